/* rtl/ctok_pkg.sv */
package ctok_pkg;

  localparam int POS_WIDTH_DEF = 20;
  localparam int OFS_W = 20;
  localparam int Q_DEPTH = 4;

  typedef enum logic [3:0] {
    M_CODE, M_WS, M_IDENT, M_NUM, M_LCOM, M_BCOM, M_STR, M_CHR, M_PRE
  } mode_t;

  typedef enum logic [3:0] {
    K_CODE  = 4'd0,
    K_SYM   = 4'd1,
    K_ARROW = 4'd2,
    K_OPEN  = 4'd3,
    K_CLOSE = 4'd4,
    K_WS    = 4'd5,
    K_COM   = 4'd6,
    K_NUM   = 4'd7,
    K_ID    = 4'd8,
    K_STR   = 4'd9,
    K_CHR   = 4'd10,
    K_PRE   = 4'd11,
    K_EOF   = 4'd12,
    K_ECOM  = 4'd13,
    K_ESTR  = 4'd14,
    K_ECHR  = 4'd15
  } kind_t;

  // one token as it travels from lexer to output queue
  typedef struct packed {
    kind_t            kind;
    logic [OFS_W-1:0] tok_start;
    logic [OFS_W-1:0] tok_end;
    logic             last;
  } tok_t;

  // tokens caused by one byte
  typedef struct packed {
    tok_t       t0;
    tok_t       t1;
    logic [1:0] n;
  } tok_pair_t;

endpackage

/* rtl/ctok_front.sv */
module ctok_front #(
  parameter int POS_WIDTH = ctok_pkg::POS_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ch_valid,
  input  logic [7:0]          ch,
  output ctok_pkg::tok_pair_t toks
);

  localparam logic [POS_WIDTH-1:0] PMAX = {POS_WIDTH{1'b1}};

  ctok_pkg::mode_t      mode_r, mode_nxt;
  logic [1:0]           look_r, look_nxt;
  logic                 esc_r, esc_nxt;
  logic                 ls_r, ls_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] ts_r, ts_nxt;
  logic                 halt_r, halt_nxt;

  function automatic logic [POS_WIDTH-1:0] inc_p(input logic [POS_WIDTH-1:0] p);
    return (p == PMAX) ? PMAX : p + 1'b1;
  endfunction

  function automatic logic [POS_WIDTH-1:0] dec_p(input logic [POS_WIDTH-1:0] p);
    return (p == '0) ? '0 : p - 1'b1;
  endfunction

  function automatic logic [ctok_pkg::OFS_W-1:0] ofs(input logic [POS_WIDTH-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[ctok_pkg::OFS_W-1:0];
  endfunction

  // append a token unless both slots are taken
  function automatic ctok_pkg::tok_pair_t put(input ctok_pkg::tok_pair_t s,
                                              input ctok_pkg::kind_t k,
                                              input logic [POS_WIDTH-1:0] a,
                                              input logic [POS_WIDTH-1:0] b);
    ctok_pkg::tok_pair_t r;
    ctok_pkg::tok_t      t;
    r = s;
    t.kind = k;
    t.tok_start = ofs(a);
    t.tok_end = ofs(b);
    t.last = 1'b0;
    if (s.n == 2'd0) begin
      r.t0 = t;
      r.n = 2'd1;
    end else if (s.n == 2'd1) begin
      r.t1 = t;
      r.n = 2'd2;
    end
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // per-byte lexer step
  always_comb begin
    ctok_pkg::tok_pair_t  s;
    logic                 do_code;
    logic [1:0]           lk;
    logic [POS_WIDTH-1:0] p;
    logic [POS_WIDTH-1:0] e;
    logic                 str;
    s = '0;
    do_code = 1'b0;
    lk = 2'd0;
    p = pos_r;
    mode_nxt = mode_r;
    look_nxt = look_r;
    esc_nxt = esc_r;
    ts_nxt = ts_r;
    halt_nxt = halt_r;
    str = (mode_r == ctok_pkg::M_STR);
    e = '0;
    if (!halt_r) begin
      case (mode_r)
        ctok_pkg::M_WS, ctok_pkg::M_IDENT, ctok_pkg::M_NUM: begin
          if (!((mode_r == ctok_pkg::M_WS && is_space(ch)) ||
                (mode_r == ctok_pkg::M_IDENT &&
                 (is_alpha(ch) || is_digit(ch) || ch == "_")) ||
                (mode_r == ctok_pkg::M_NUM && is_digit(ch)))) begin
            s = put(s, (mode_r == ctok_pkg::M_WS) ? ctok_pkg::K_WS :
                       (mode_r == ctok_pkg::M_IDENT) ? ctok_pkg::K_ID : ctok_pkg::K_NUM,
                    ts_nxt, p);
            mode_nxt = ctok_pkg::M_CODE;
            look_nxt = 2'd0;
            ts_nxt = p;
            do_code = 1'b1;
          end
        end
        ctok_pkg::M_LCOM: begin
          if (ch == 8'h0a) begin
            s = put(s, ctok_pkg::K_COM, ts_nxt, inc_p(p));
            mode_nxt = ctok_pkg::M_CODE;
            look_nxt = 2'd0;
            ts_nxt = inc_p(p);
          end else if (ch == 8'd0) begin
            s = put(s, ctok_pkg::K_COM, ts_nxt, p);
            mode_nxt = ctok_pkg::M_CODE;
            look_nxt = 2'd0;
            ts_nxt = p;
            do_code = 1'b1;
          end
        end
        ctok_pkg::M_BCOM: begin
          if (ch == 8'd0) begin
            s = put(s, ctok_pkg::K_ECOM, ts_nxt, p);
            halt_nxt = 1'b1;
            s = put(s, ctok_pkg::K_EOF, p, p);
          end else if (look_r == 2'd1 && ch == "/") begin
            s = put(s, ctok_pkg::K_COM, ts_nxt, inc_p(p));
            mode_nxt = ctok_pkg::M_CODE;
            look_nxt = 2'd0;
            ts_nxt = inc_p(p);
          end else begin
            look_nxt = (ch == "*") ? 2'd1 : 2'd0;
          end
        end
        ctok_pkg::M_STR, ctok_pkg::M_CHR: begin
          if (ch == 8'd0) begin
            s = put(s, str ? ctok_pkg::K_ESTR : ctok_pkg::K_ECHR, ts_nxt, p);
            halt_nxt = 1'b1;
          end else if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (ch == 8'h5c) begin
            esc_nxt = 1'b1;
          end else if (str && ch == 8'h0a) begin
            s = put(s, ctok_pkg::K_ESTR, ts_nxt, p);
            halt_nxt = 1'b1;
          end else if (ch == (str ? 8'h22 : 8'h27)) begin
            s = put(s, str ? ctok_pkg::K_STR : ctok_pkg::K_CHR, ts_nxt, inc_p(p));
            mode_nxt = ctok_pkg::M_CODE;
            look_nxt = 2'd0;
            ts_nxt = inc_p(p);
          end
        end
        ctok_pkg::M_PRE: begin
          if (ch == 8'h0a || ch == 8'd0) begin
            s = put(s, ctok_pkg::K_PRE, ts_nxt, p);
            mode_nxt = ctok_pkg::M_CODE;
            look_nxt = 2'd0;
            ts_nxt = p;
            do_code = 1'b1;
          end
        end
        default: begin
          mode_nxt = ctok_pkg::M_CODE;
          do_code = 1'b1;
        end
      endcase

      // plain code handling, with the pending lookahead
      if (do_code) begin
        lk = look_nxt;
        look_nxt = 2'd0;
        if (lk == 2'd1 && ch == ">") begin
          e = dec_p(p);
          if (e > ts_nxt) s = put(s, ctok_pkg::K_CODE, ts_nxt, e);
          s = put(s, ctok_pkg::K_ARROW, e, inc_p(p));
          ts_nxt = inc_p(p);
        end else if (lk == 2'd2 && (ch == "/" || ch == "*")) begin
          e = dec_p(p);
          if (e > ts_nxt) s = put(s, ctok_pkg::K_CODE, ts_nxt, e);
          mode_nxt = (ch == "/") ? ctok_pkg::M_LCOM : ctok_pkg::M_BCOM;
          ts_nxt = e;
        end else if (ch == 8'd0) begin
          if (p > ts_nxt) s = put(s, ctok_pkg::K_CODE, ts_nxt, p);
          s = put(s, ctok_pkg::K_EOF, p, p);
          ts_nxt = p;
          halt_nxt = 1'b1;
        end else if (is_space(ch) || is_alpha(ch) || ch == "_" || is_digit(ch) ||
                     ch == 8'h27 || ch == 8'h22 || (ch == "#" && ls_r)) begin
          if (p > ts_nxt) s = put(s, ctok_pkg::K_CODE, ts_nxt, p);
          ts_nxt = p;
          if (is_space(ch)) mode_nxt = ctok_pkg::M_WS;
          else if (is_digit(ch)) mode_nxt = ctok_pkg::M_NUM;
          else if (ch == 8'h27) mode_nxt = ctok_pkg::M_CHR;
          else if (ch == 8'h22) mode_nxt = ctok_pkg::M_STR;
          else if (ch == "#") mode_nxt = ctok_pkg::M_PRE;
          else mode_nxt = ctok_pkg::M_IDENT;
          if (ch == 8'h27 || ch == 8'h22) esc_nxt = 1'b0;
        end else if (ch == ";" || ch == "." || ch == "," || ch == "=" || ch == "*" ||
                     ch == "(" || ch == "[" || ch == "{" ||
                     ch == ")" || ch == "]" || ch == "}") begin
          if (p > ts_nxt) s = put(s, ctok_pkg::K_CODE, ts_nxt, p);
          if (ch == "(" || ch == "[" || ch == "{") s = put(s, ctok_pkg::K_OPEN, p, inc_p(p));
          else if (ch == ")" || ch == "]" || ch == "}")
            s = put(s, ctok_pkg::K_CLOSE, p, inc_p(p));
          else s = put(s, ctok_pkg::K_SYM, p, inc_p(p));
          ts_nxt = inc_p(p);
        end else if (ch == "-") begin
          look_nxt = 2'd1;
        end else if (ch == "/") begin
          look_nxt = 2'd2;
        end
      end
    end

    // mark the last token of this byte
    if (s.n == 2'd2) s.t1.last = 1'b1;
    else if (s.n == 2'd1) s.t0.last = 1'b1;
    toks = s;
    if (!ch_valid) toks.n = 2'd0;

    ls_nxt = (ch == 8'h0a);
    pos_nxt = inc_p(p);
  end

  // lexer state, advanced per accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ctok_pkg::M_CODE;
      look_r <= 2'd0;
      esc_r  <= 1'b0;
      ls_r   <= 1'b1;
      pos_r  <= '0;
      ts_r   <= '0;
      halt_r <= 1'b0;
    end else if (ch_valid) begin
      mode_r <= mode_nxt;
      look_r <= look_nxt;
      esc_r  <= esc_nxt;
      ls_r   <= ls_nxt;
      pos_r  <= pos_nxt;
      ts_r   <= ts_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

/* rtl/ctok_queue.sv */
module ctok_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  ctok_pkg::tok_pair_t push,
  output logic                room2,
  output logic                pop_valid,
  input  logic                pop_ready,
  output ctok_pkg::tok_t      head
);

  localparam int D = ctok_pkg::Q_DEPTH;
  localparam int AW = $clog2(D);

  ctok_pkg::tok_t  q_r [D];
  logic [AW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            pop;

  assign room2 = cnt_r <= (AW+1)'(D - 2);
  assign pop_valid = cnt_r != '0;
  assign head = q_r[rd_r];
  assign pop = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_nxt = wr_r + AW'(push.n);
    rd_nxt = rd_r + AW'(pop);
    cnt_nxt = cnt_r + (AW+1)'(push.n) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // token storage, up to two writes per cycle
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) q_r[wr_r] <= push.t0;
    if (push.n == 2'd2) q_r[wr_r + AW'(1)] <= push.t1;
  end

endmodule

/* rtl/c_source_tokenizer.sv */
// c_source_tokenizer: streaming lexer for C source text
// in channel: one source byte per transaction in in_tdata; byte 0 ends the text
// out channel: one token per transaction; kind in out_tuser, offsets in out_tdata,
//   out_tlast marks the last token caused by one input byte
// each byte causes zero, one or two tokens; the lexer front end updates its
//   state per accepted byte and pushes the tokens into a four-entry queue
// the tokens of a byte are registered into the queue when the byte is taken
// throughput: one byte per cycle while the queue has room for two tokens;
//   bytes causing two tokens are drained at one token per cycle by the out port while out_tready is high
// after the eof token or an error token no further tokens come until reset
// reset (rst_n low, synchronous) empties the queue and returns to code scanning
//   at offset 0; a stalled receiver fills the queue and in_tready then drops
// offsets saturate at 2^POS_WIDTH-1 and are reported in 20 bits
module c_source_tokenizer #(
  parameter int POS_WIDTH = ctok_pkg::POS_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [19:0] tok_start, [39:20] tok_end
  output logic [3:0]  out_tuser,  // [3:0] kind
  output logic        out_tlast
);

  ctok_pkg::tok_pair_t toks;
  ctok_pkg::tok_t      head;
  logic                room2;

  ctok_front #(.POS_WIDTH(POS_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .ch_valid (in_tvalid && in_tready),
    .ch       (in_tdata),
    .toks     (toks)
  );

  ctok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (toks),
    .room2     (room2),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .head      (head)
  );

  assign in_tready = room2;
  assign out_tdata = {head.tok_end, head.tok_start};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam logic [19:0] POS_MAX = 20'hFFFFF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    ctok_pkg::kind_t kind;
    logic [19:0]     s;
    logic [19:0]     e;
    logic            last;
  } token_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  c_source_tokenizer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // source text still to send, and tokens still owed by the lexer
  logic [7:0] src_q[$];
  token_rec_t tok_q[$];
  token_rec_t step_toks[$];
  int errors = 0, bytes_sent = 0, toks_seen = 0, cycles = 0;
  bit seen_kind[16];

  // shadow lexer state
  ctok_pkg::mode_t lx_mode;
  logic [1:0]      lx_look;
  logic            lx_esc, lx_bol, lx_halt;
  logic [19:0]     lx_pos, lx_tstart;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic logic [19:0] inc(input logic [19:0] p);
    return (p == POS_MAX) ? POS_MAX : p + 20'd1;
  endfunction

  function automatic logic [19:0] dec(input logic [19:0] p);
    return (p == 20'd0) ? 20'd0 : p - 20'd1;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alp(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  task automatic emit(input ctok_pkg::kind_t k, input logic [19:0] s, input logic [19:0] e);
    token_rec_t t;
    if (step_toks.size() < 2) begin
      t.kind = k; t.s = s; t.e = e; t.last = 1'b0;
      step_toks.push_back(t);
    end
  endtask

  task automatic flush_code(input logic [19:0] e);
    if (e > lx_tstart) emit(ctok_pkg::K_CODE, lx_tstart, e);
    lx_tstart = e;
  endtask

  task automatic enter_mode(input ctok_pkg::mode_t m, input logic [19:0] p);
    flush_code(p);
    lx_mode = m;
    lx_tstart = p;
  endtask

  task automatic close_token(input ctok_pkg::kind_t k, input logic [19:0] e);
    emit(k, lx_tstart, e);
    lx_mode = ctok_pkg::M_CODE;
    lx_look = 2'd0;
    lx_tstart = e;
  endtask

  task automatic single(input ctok_pkg::kind_t k, input logic [19:0] p);
    flush_code(p);
    emit(k, p, inc(p));
    lx_tstart = inc(p);
  endtask

  // a byte seen in plain code scanning
  task automatic scan_code(input logic [7:0] c, input logic [19:0] p);
    logic [1:0] lk;
    lk = lx_look;
    lx_look = 2'd0;
    if (lk == 2'd1 && c == ">") begin
      flush_code(dec(p));
      emit(ctok_pkg::K_ARROW, dec(p), inc(p));
      lx_tstart = inc(p);
    end else if (lk == 2'd2 && (c == "/" || c == "*")) begin
      enter_mode(c == "/" ? ctok_pkg::M_LCOM : ctok_pkg::M_BCOM, dec(p));
    end else if (c == 8'd0) begin
      flush_code(p);
      emit(ctok_pkg::K_EOF, p, p);
      lx_halt = 1'b1;
    end else if (is_ws(c)) enter_mode(ctok_pkg::M_WS, p);
    else if (is_alp(c) || c == "_") enter_mode(ctok_pkg::M_IDENT, p);
    else if (is_dig(c)) enter_mode(ctok_pkg::M_NUM, p);
    else begin
      case (c)
        "'": begin lx_esc = 1'b0; enter_mode(ctok_pkg::M_CHR, p); end
        "\"": begin lx_esc = 1'b0; enter_mode(ctok_pkg::M_STR, p); end
        ";", ".", ",", "=", "*": single(ctok_pkg::K_SYM, p);
        "(", "[", "{": single(ctok_pkg::K_OPEN, p);
        ")", "]", "}": single(ctok_pkg::K_CLOSE, p);
        "-": lx_look = 2'd1;
        "/": lx_look = 2'd2;
        "#": if (lx_bol) enter_mode(ctok_pkg::M_PRE, p);
        default: ;
      endcase
    end
  endtask

  // work out the tokens one accepted byte causes
  task automatic lex_byte(input logic [7:0] c);
    logic [19:0] p;
    bit is_str;
    p = lx_pos;
    step_toks.delete();
    if (lx_halt) return;
    case (lx_mode)
      ctok_pkg::M_WS: if (!is_ws(c)) begin
        close_token(ctok_pkg::K_WS, p); scan_code(c, p);
      end
      ctok_pkg::M_IDENT: if (!(is_alp(c) || is_dig(c) || c == "_")) begin
        close_token(ctok_pkg::K_ID, p); scan_code(c, p);
      end
      ctok_pkg::M_NUM: if (!is_dig(c)) begin
        close_token(ctok_pkg::K_NUM, p); scan_code(c, p);
      end
      ctok_pkg::M_LCOM: begin
        if (c == "\n") close_token(ctok_pkg::K_COM, inc(p));
        else if (c == 8'd0) begin close_token(ctok_pkg::K_COM, p); scan_code(c, p); end
      end
      ctok_pkg::M_BCOM: begin
        if (c == 8'd0) begin
          emit(ctok_pkg::K_ECOM, lx_tstart, p);
          lx_halt = 1'b1;
          emit(ctok_pkg::K_EOF, p, p);
        end else if (lx_look == 2'd1 && c == "/") close_token(ctok_pkg::K_COM, inc(p));
        else lx_look = (c == "*") ? 2'd1 : 2'd0;
      end
      ctok_pkg::M_STR, ctok_pkg::M_CHR: begin
        is_str = (lx_mode == ctok_pkg::M_STR);
        if (c == 8'd0) begin
          emit(is_str ? ctok_pkg::K_ESTR : ctok_pkg::K_ECHR, lx_tstart, p);
          lx_halt = 1'b1;
        end else if (lx_esc) lx_esc = 1'b0;
        else if (c == "\\") lx_esc = 1'b1;
        else if (is_str && c == "\n") begin
          emit(ctok_pkg::K_ESTR, lx_tstart, p);
          lx_halt = 1'b1;
        end else if (c == (is_str ? 8'h22 : 8'h27))
          close_token(is_str ? ctok_pkg::K_STR : ctok_pkg::K_CHR, inc(p));
      end
      ctok_pkg::M_PRE: if (c == "\n" || c == 8'd0) begin
        close_token(ctok_pkg::K_PRE, p); scan_code(c, p);
      end
      default: begin lx_mode = ctok_pkg::M_CODE; scan_code(c, p); end
    endcase
    lx_bol = (c == "\n");
    lx_pos = inc(p);
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) tok_q.push_back(step_toks[i]);
  endtask

  // text building helpers
  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) src_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic void add_run(input string s, input int lo, input int hi);
    int n;
    n = $urandom_range(hi, lo);
    for (int i = 0; i < n; i++) src_q.push_back(pick(s));
  endfunction

  // one random fragment of mostly well-formed source
  function automatic void add_fragment();
    string alp, dig, sp;
    alp = "abcxyzQRS_Tm";
    dig = "0123456789";
    sp = " \t\n\r\013\014";
    case ($urandom_range(13))
      0: begin src_q.push_back(pick(alp)); add_run({alp, dig}, 0, 6); end
      1: add_run(dig, 1, 5);
      2: add_run(sp, 1, 4);
      3: begin add_text("//"); add_run("ab */-\\#'\"", 0, 6); add_text("\n"); end
      4: begin add_text("/*"); add_run("a*\n/ -x", 0, 8); add_text("*/"); end
      5: begin
        add_text("\"");
        repeat ($urandom_range(5)) begin
          if ($urandom_range(3) == 0) begin add_text("\\"); src_q.push_back(pick("\"n\\\n'"));
          end else src_q.push_back(pick("ab 'x-/#;"));
        end
        add_text("\"");
      end
      6: begin
        add_text("'");
        if ($urandom_range(1)) begin add_text("\\"); src_q.push_back(pick("'n\\"));
        end else src_q.push_back(pick("a\n\"x"));
        add_text("'");
      end
      7: begin add_text("\n#"); add_run({alp, " /*<>"}, 0, 8); add_text("\n"); end
      8: add_text("->");
      9: src_q.push_back(pick(";.,=*()[]{}"));
      10: src_q.push_back(pick("-/#+<>!&|%^~?:"));
      11: src_q.push_back(8'($urandom_range(255, 1)));
      12: add_text("\n");
      default: add_run("+-<>/!&|", 1, 3);
    endcase
  endfunction

  // sender
  int in_gap = 0;
  bit in_calm = 1'b0;
  bit sender_paused = 1'b0, pause_done = 1'b0;

  function automatic int gap_len(input bit calm);
    if (calm) return 0;
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(3, 1);
      3: return ($urandom_range(4) == 0) ? $urandom_range(30, 10) : 1;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'd0;
    end else begin
      if (in_tvalid && in_tready) begin
        lex_byte(in_tdata);
        bytes_sent++;
        if (bytes_sent == 250 && !pause_done) sender_paused = 1'b1;
      end
      if (sender_paused && tok_q.size() == 0) begin
        sender_paused = 1'b0;
        pause_done = 1'b1;
      end
      if (cycles % 128 == 0) in_calm = ($urandom_range(3) == 0);
      // only move on once the current transaction is taken
      if (!(in_tvalid && !in_tready)) begin
        if (sender_paused || src_q.size() == 0) in_tvalid <= 1'b0;
        else if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else begin
          in_tvalid <= 1'b1;
          in_tdata <= src_q.pop_front();
          in_gap = gap_len(in_calm);
        end
      end
    end
  end

  // receiver and checker
  int out_gap = 0, long_hold = 0;
  bit out_calm = 1'b0, hold_done = 1'b0;
  token_rec_t want;

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else begin
      if (out_tvalid && out_tready) begin
        toks_seen++;
        seen_kind[out_tuser] = 1'b1;
        if (tok_q.size() == 0)
          report_mismatch($sformatf("unexpected token kind %0d", out_tuser));
        else begin
          want = tok_q.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", out_tuser, want.kind));
          if (out_tdata[19:0] !== want.s)
            report_mismatch($sformatf("start %0d, expected %0d", out_tdata[19:0], want.s));
          if (out_tdata[39:20] !== want.e)
            report_mismatch($sformatf("end %0d, expected %0d", out_tdata[39:20], want.e));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", out_tlast, want.last));
        end
      end
      if (cycles % 100 == 0) out_calm = ($urandom_range(3) == 0);
      // one long hold-off so the queue fills and the input stalls
      if (!hold_done && bytes_sent >= 100) begin
        long_hold = 300;
        hold_done = 1'b1;
      end
      if (long_hold > 0) begin
        long_hold--;
        out_tready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = gap_len(out_calm);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout: %0d tokens still owed", tok_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int kinds;
    lx_mode = ctok_pkg::M_CODE; lx_look = 2'd0; lx_esc = 1'b0; lx_bol = 1'b1;
    lx_pos = 20'd0; lx_tstart = 20'd0; lx_halt = 1'b0;

    // directed text: line-start preproc at offset 0, arrows, pending '-' and '/',
    // comments, escapes, brackets, symbols, stray '#', high bytes
    add_text("#inc <x>\n");
    add_text("a->b;x-y/ z//c\n");
    add_text("/*a**/'\\''\"a\\\"b\\\\\"");
    add_text("(1)[]{}.,=*\t\013\014\r ");
    add_text("c#d _Z9 -\n#p\n#");
    src_q.push_back(8'hFF); src_q.push_back(8'h80); src_q.push_back(8'h7F);
    add_text("'\n'-");
    src_q.push_back(8'h01);

    // random source text
    while (src_q.size() < 520) add_fragment();

    // one way of ending the text
    case ($urandom_range(4))
      0: add_text("/*open*");
      1: add_text("\"open");
      2: add_text("'op\\");
      3: add_text("\"line\n");
      default: add_text("//tail");
    endcase
    src_q.push_back(8'd0);
    // bytes after the halt give nothing
    repeat (4) src_q.push_back(8'($urandom_range(255, 1)));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    wait (src_q.size() == 0 && !in_tvalid);
    wait (tok_q.size() == 0);
    repeat (20) @(posedge clk);
    if (out_tvalid) report_mismatch("token left in the block after the text ended");

    kinds = 0;
    foreach (seen_kind[i]) kinds += seen_kind[i];
    $display("lexed %0d source bytes into %0d tokens", bytes_sent, toks_seen);
    $display("%0d distinct token kinds seen, input and output stalls included", kinds);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ctok_pkg.sv
rtl/ctok_front.sv
rtl/ctok_queue.sv
rtl/c_source_tokenizer.sv
sim/testbench.sv
